@@ rtl/obsb_pkg.sv @@
// Shared types, constants and arithmetic helpers for the oriented box support unit.
package obsb_pkg;

    localparam int AXES        = 3;
    localparam int CORNERS     = 8;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int HE_W        = 30;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_HALF_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_HALF_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_HALF_Z = 2'd2;

    // Input beat, lowest bits first: dir x/y/z, pos x/y/z, quat w/x/y/z, bias, pad
    typedef struct packed {
        logic              pad;
        logic [30:0]       bias;
        logic [15:0]       qz;
        logic [15:0]       qy;
        logic [15:0]       qx;
        logic [15:0]       qw;
        logic [2:0][31:0]  pos;
        logic [2:0][31:0]  dir;
    } in_t;

    // Output beat, lowest bits first: support x/y/z, bound min x/y/z, bound max x/y/z
    typedef struct packed {
        logic [2:0][31:0]  bmax;
        logic [2:0][31:0]  bmin;
        logic [2:0][31:0]  support;
    } result_t;

    // One candidate corner in the selection tree
    typedef struct packed {
        logic signed [65:0] dot;
        logic [2:0][31:0]   p;
        logic [2:0][32:0]   mn;
        logic [2:0][32:0]   mx;
    } cand_t;

    // Geometry result handed to the normalisation pipe
    typedef struct packed {
        logic [2:0][31:0]  best;
        logic [2:0][31:0]  pos;
        logic [30:0]       bias;
        logic [2:0][31:0]  mn;
        logic [2:0][31:0]  mx;
    } geom_t;

    typedef struct packed {
        logic [63:0]       rem;
        logic [31:0]       root;
        logic [2:0][32:0]  bp;
        logic [2:0]        neg;
        logic [2:0][62:0]  num;
        logic [2:0][31:0]  mn;
        logic [2:0][31:0]  mx;
    } root_t;

    typedef struct packed {
        logic [2:0][62:0]  rem;
        logic [2:0][30:0]  quo;
        logic [31:0]       len;
        logic [2:0][32:0]  bp;
        logic [2:0]        neg;
        logic [2:0][31:0]  mn;
        logic [2:0][31:0]  mx;
    } quot_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // Later corner replaces the earlier one only when strictly greater
    function automatic cand_t merge(input cand_t l, input cand_t r);
        cand_t m;
        m = l;
        if (r.dot > l.dot)
        begin
            m.dot = r.dot;
            m.p   = r.p;
        end
        for (int i = 0; i < AXES; i++)
        begin
            if ($signed(r.mn[i]) < $signed(l.mn[i]))
                m.mn[i] = r.mn[i];
            if ($signed(r.mx[i]) > $signed(l.mx[i]))
                m.mx[i] = r.mx[i];
        end
        return m;
    endfunction

    // One result bit of the integer square root
    function automatic root_t root_step(input root_t x, input int unsigned b);
        root_t       y;
        logic [65:0] trial;
        y = x;
        trial = ({34'd0, x.root} << (b + 1)) | (66'd1 << (2 * b));
        if ({2'b00, x.rem} >= trial)
        begin
            y.rem  = x.rem - trial[63:0];
            y.root = x.root | (32'd1 << b);
        end
        return y;
    endfunction

    // One quotient bit for each axis
    function automatic quot_t quot_step(input quot_t x, input int unsigned b);
        quot_t       y;
        logic [62:0] cmp;
        y = x;
        cmp = {31'd0, x.len} << b;
        for (int i = 0; i < AXES; i++)
        begin
            if (x.rem[i] >= cmp)
            begin
                y.rem[i] = x.rem[i] - cmp;
                y.quo[i] = x.quo[i] | (31'd1 << b);
            end
        end
        return y;
    endfunction

endpackage

@@ rtl/obsb_geom.sv @@
// Rotation matrix, rotated corners, dot products and corner selection with bounds.
module obsb_geom (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  obsb_pkg::in_t                  in_data,
    input  logic [2:0][obsb_pkg::HE_W-1:0] he,
    output logic                           geom_valid,
    output obsb_pkg::geom_t                geom
);
    import obsb_pkg::*;

    // stage A: matrix
    logic signed [33:0] a_r_reg [AXES][AXES];
    logic signed [33:0] a_r_next [AXES][AXES];
    logic [2:0][31:0]   a_d_reg, a_pos_reg;
    logic [30:0]        a_bias_reg;
    // stage B: matrix times half extents
    logic signed [64:0] b_t_reg [AXES][AXES];
    logic signed [64:0] b_t_next [AXES][AXES];
    logic [2:0][31:0]   b_d_reg, b_pos_reg;
    logic [30:0]        b_bias_reg;
    // stage C: rotated corners
    logic [2:0][31:0]   c_p_reg [CORNERS];
    logic [2:0][31:0]   c_p_next [CORNERS];
    logic [2:0][31:0]   c_d_reg, c_pos_reg;
    logic [30:0]        c_bias_reg;
    // stages D to F: selection tree
    cand_t              d_reg [CORNERS];
    cand_t              d_next [CORNERS];
    cand_t              e_reg [CORNERS/2];
    cand_t              f_reg [CORNERS/4];
    cand_t              g_win;
    logic [2:0][31:0]   d_pos_reg, e_pos_reg, f_pos_reg;
    logic [30:0]        d_bias_reg, e_bias_reg, f_bias_reg;
    geom_t              g_reg;
    logic [6:0]         v_reg;

    always_comb
    begin
        logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        xx = $signed(in_data.qx) * $signed(in_data.qx);
        yy = $signed(in_data.qy) * $signed(in_data.qy);
        zz = $signed(in_data.qz) * $signed(in_data.qz);
        xy = $signed(in_data.qx) * $signed(in_data.qy);
        xz = $signed(in_data.qx) * $signed(in_data.qz);
        yz = $signed(in_data.qy) * $signed(in_data.qz);
        wx = $signed(in_data.qw) * $signed(in_data.qx);
        wy = $signed(in_data.qw) * $signed(in_data.qy);
        wz = $signed(in_data.qw) * $signed(in_data.qz);
        a_r_next[0][0] = 34'sd536870912 - (34'(yy) + 34'(zz));
        a_r_next[0][1] = 34'(xy) - 34'(wz);
        a_r_next[0][2] = 34'(xz) + 34'(wy);
        a_r_next[1][0] = 34'(xy) + 34'(wz);
        a_r_next[1][1] = 34'sd536870912 - (34'(xx) + 34'(zz));
        a_r_next[1][2] = 34'(yz) - 34'(wx);
        a_r_next[2][0] = 34'(xz) - 34'(wy);
        a_r_next[2][1] = 34'(yz) + 34'(wx);
        a_r_next[2][2] = 34'sd536870912 - (34'(xx) + 34'(yy));
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            for (int j = 0; j < AXES; j++)
                b_t_next[i][j] = a_r_reg[i][j] * $signed({1'b0, he[j]});
    end

    // Corner k takes +h on axis j when bit j of k is set; round half up by 2^28
    always_comb
    begin
        logic signed [66:0] acc;
        acc = '0;
        for (int k = 0; k < CORNERS; k++)
            for (int i = 0; i < AXES; i++)
            begin
                acc = 67'sd268435456;
                for (int j = 0; j < AXES; j++)
                begin
                    if (((k >> j) & 1) == 1)
                        acc = acc + 67'(b_t_reg[i][j]);
                    else
                        acc = acc - 67'(b_t_reg[i][j]);
                end
                c_p_next[k][i] = sat32(64'(acc >>> 29));
            end
    end

    always_comb
    begin
        logic signed [63:0] prod;
        prod = '0;
        for (int k = 0; k < CORNERS; k++)
        begin
            d_next[k].dot = '0;
            d_next[k].p   = c_p_reg[k];
            for (int i = 0; i < AXES; i++)
            begin
                prod = $signed(c_d_reg[i]) * $signed(c_p_reg[k][i]);
                d_next[k].dot = d_next[k].dot + 66'(prod);
                d_next[k].mn[i] = 33'($signed(c_pos_reg[i])) + 33'($signed(c_p_reg[k][i]));
                d_next[k].mx[i] = d_next[k].mn[i];
            end
        end
    end

    assign g_win = merge(f_reg[0], f_reg[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_r_reg    <= a_r_next;
            a_d_reg    <= in_data.dir;
            a_pos_reg  <= in_data.pos;
            a_bias_reg <= in_data.bias;
            b_t_reg    <= b_t_next;
            b_d_reg    <= a_d_reg;
            b_pos_reg  <= a_pos_reg;
            b_bias_reg <= a_bias_reg;
            c_p_reg    <= c_p_next;
            c_d_reg    <= b_d_reg;
            c_pos_reg  <= b_pos_reg;
            c_bias_reg <= b_bias_reg;
            d_reg      <= d_next;
            d_pos_reg  <= c_pos_reg;
            d_bias_reg <= c_bias_reg;
            for (int n = 0; n < CORNERS / 2; n++)
                e_reg[n] <= merge(d_reg[2 * n], d_reg[2 * n + 1]);
            e_pos_reg  <= d_pos_reg;
            e_bias_reg <= d_bias_reg;
            for (int n = 0; n < CORNERS / 4; n++)
                f_reg[n] <= merge(e_reg[2 * n], e_reg[2 * n + 1]);
            f_pos_reg  <= e_pos_reg;
            f_bias_reg <= e_bias_reg;
            g_reg.best <= g_win.p;
            g_reg.pos  <= f_pos_reg;
            g_reg.bias <= f_bias_reg;
            for (int i = 0; i < AXES; i++)
            begin
                g_reg.mn[i] <= sat32(64'($signed(g_win.mn[i])));
                g_reg.mx[i] <= sat32(64'($signed(g_win.mx[i])));
            end
        end
    end

    assign geom_valid = v_reg[6];
    assign geom       = g_reg;

endmodule

@@ rtl/obsb_norm.sv @@
// Corner length by pipelined square root, bias offset by pipelined division, final sums.
module obsb_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  obsb_pkg::geom_t   geom,
    output logic              out_valid,
    output obsb_pkg::result_t res
);
    import obsb_pkg::*;

    root_t                 h_reg, h_next;
    logic                  h_v_reg;
    root_t                 rt_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] rt_v_reg;
    quot_t                 q_in;
    quot_t                 qt_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0]  qt_v_reg;
    result_t               res_reg, res_next;
    logic                  res_v_reg;

    always_comb
    begin
        logic signed [31:0] bs;
        logic [31:0]        m;
        logic [63:0]        s;
        s = '0;
        m = '0;
        bs = '0;
        h_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            bs = $signed(geom.best[i]);
            m  = bs[31] ? (~geom.best[i] + 32'd1) : geom.best[i];
            s  = s + ({32'd0, m} * {32'd0, m});
            h_next.num[i] = {32'd0, geom.bias} * {31'd0, m};
            h_next.bp[i]  = 33'(bs) + 33'($signed(geom.pos[i]));
            h_next.neg[i] = bs[31];
        end
        h_next.rem  = s;
        h_next.root = '0;
        h_next.mn   = geom.mn;
        h_next.mx   = geom.mx;
    end

    always_comb
    begin
        q_in.rem = rt_reg[SQRT_STEPS-1].num;
        q_in.quo = '0;
        q_in.len = rt_reg[SQRT_STEPS-1].root;
        q_in.bp  = rt_reg[SQRT_STEPS-1].bp;
        q_in.neg = rt_reg[SQRT_STEPS-1].neg;
        q_in.mn  = rt_reg[SQRT_STEPS-1].mn;
        q_in.mx  = rt_reg[SQRT_STEPS-1].mx;
    end

    // Zero length means a zero corner: drop the offset
    always_comb
    begin
        logic signed [33:0] off;
        logic signed [33:0] sum;
        off = '0;
        sum = '0;
        for (int i = 0; i < AXES; i++)
        begin
            off = $signed({3'b000, qt_reg[DIV_STEPS-1].quo[i]});
            if (qt_reg[DIV_STEPS-1].len == 32'd0)
                off = '0;
            else if (qt_reg[DIV_STEPS-1].neg[i])
                off = -off;
            sum = 34'($signed(qt_reg[DIV_STEPS-1].bp[i])) + off;
            res_next.support[i] = sat32(64'(sum));
        end
        res_next.bmin = qt_reg[DIV_STEPS-1].mn;
        res_next.bmax = qt_reg[DIV_STEPS-1].mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_v_reg   <= 1'b0;
            rt_v_reg  <= '0;
            qt_v_reg  <= '0;
            res_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            h_v_reg   <= in_valid;
            rt_v_reg  <= {rt_v_reg[SQRT_STEPS-2:0], h_v_reg};
            qt_v_reg  <= {qt_v_reg[DIV_STEPS-2:0], rt_v_reg[SQRT_STEPS-1]};
            res_v_reg <= qt_v_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg <= h_next;
            for (int s = 0; s < SQRT_STEPS; s++)
            begin
                if (s == 0)
                    rt_reg[s] <= root_step(h_reg, SQRT_STEPS - 1);
                else
                    rt_reg[s] <= root_step(rt_reg[s-1], SQRT_STEPS - 1 - s);
            end
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                if (s == 0)
                    qt_reg[s] <= quot_step(q_in, DIV_STEPS - 1);
                else
                    qt_reg[s] <= quot_step(qt_reg[s-1], DIV_STEPS - 1 - s);
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = res_v_reg;
    assign res       = res_reg;

endmodule

@@ rtl/oriented_box_support_and_bounds_unit.sv @@
// Top level of the oriented box support point and world bounds unit.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  query: direction, position, quaternion, bias
//  m_*       out        m_tvalid / m_tready  support point, bound minimum, bound maximum
//  cfg_*     in         cfg_we               half extent x, y, z
//
// One query is accepted every cycle while the output is not stalled; a result passes through
// 7 geometry stages, 1 setup stage, 32 root stages, 31 divide stages and 1 output stage.
// The root and divide chains, one result bit per stage, set the latency.
// A stalled output holds the whole pipeline; bubbles fill while the output is empty.
// Reset clears all valid bits and sets every half extent to 1.0.
module oriented_box_support_and_bounds_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // dir_x, dir_y, dir_z, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, bias, pad
    input  logic [287:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // support_x/y/z, bound_min_x/y/z, bound_max_x/y/z
    output logic [287:0]                  m_tdata,
    input  logic                          cfg_we,
    input  logic [obsb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [obsb_pkg::HE_W-1:0]     cfg_data
);
    import obsb_pkg::*;

    logic [2:0][HE_W-1:0] he_reg;
    logic                 adv;
    logic                 geom_valid;
    geom_t                geom;
    result_t              res;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            he_reg[0] <= 30'd65536;
            he_reg[1] <= 30'd65536;
            he_reg[2] <= 30'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_X: he_reg[0] <= cfg_data;
                REG_HALF_Y: he_reg[1] <= cfg_data;
                REG_HALF_Z: he_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    obsb_geom u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_data    (in_t'(s_tdata)),
        .he         (he_reg),
        .geom_valid (geom_valid),
        .geom       (geom)
    );

    obsb_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (geom_valid),
        .geom      (geom),
        .out_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = res;

    a_cfg_x: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_HALF_X |=> he_reg[0] == $past(cfg_data))
        else $error("half extent x not loaded");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(res.bmin[0]) <= $signed(res.bmax[0]))
                  && ($signed(res.bmin[1]) <= $signed(res.bmax[1]))
                  && ($signed(res.bmin[2]) <= $signed(res.bmax[2])))
        else $error("bound minimum above maximum");

endmodule

@@ dv/oriented_box_support_and_bounds_unit_tb.sv @@
// Self-checking testbench for the oriented box support point and world bounds unit.

class box_support_scoreboard;
    obsb_pkg::result_t pending[$];
    logic [29:0] half_ext[3];
    int errors;

    function new();
        for (int i = 0; i < 3; i++)
            half_ext[i] = 30'd65536;
        errors = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function logic [31:0] clamp32(logic signed [95:0] v);
        if (v > 96'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -96'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function obsb_pkg::result_t support_and_bounds(obsb_pkg::in_t it);
        obsb_pkg::result_t res;
        logic signed [95:0] qw, qx, qy, qz, acc, dt, bdot;
        logic signed [95:0] rot[3][3];
        logic signed [95:0] dir[3], pos[3], c[3], p[3], best[3], mn[3], mx[3], w, off;
        logic [63:0] s, len, m, q;
        qw = $signed(it.qw);
        qx = $signed(it.qx);
        qy = $signed(it.qy);
        qz = $signed(it.qz);
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = $signed(it.dir[i]);
            pos[i] = $signed(it.pos[i]);
        end
        rot[0][0] = (96'sd1 <<< 29) - (qy * qy + qz * qz);
        rot[0][1] = qx * qy - qw * qz;
        rot[0][2] = qx * qz + qw * qy;
        rot[1][0] = qx * qy + qw * qz;
        rot[1][1] = (96'sd1 <<< 29) - (qx * qx + qz * qz);
        rot[1][2] = qy * qz - qw * qx;
        rot[2][0] = qx * qz - qw * qy;
        rot[2][1] = qy * qz + qw * qx;
        rot[2][2] = (96'sd1 <<< 29) - (qx * qx + qy * qy);
        bdot = 0;
        for (int k = 0; k < 8; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c[j] = {66'd0, half_ext[j]};
                if (!k[j])
                    c[j] = -c[j];
            end
            for (int i = 0; i < 3; i++)
            begin
                acc = 96'sd1 <<< 28;
                for (int j = 0; j < 3; j++)
                    acc = acc + rot[i][j] * c[j];
                p[i] = $signed(clamp32(acc >>> 29));
            end
            dt = dir[0] * p[0] + dir[1] * p[1] + dir[2] * p[2];
            // earliest corner keeps a tie
            if (k == 0 || dt > bdot)
            begin
                bdot = dt;
                best = p;
            end
            for (int i = 0; i < 3; i++)
            begin
                w = pos[i] + p[i];
                if (k == 0 || w < mn[i])
                    mn[i] = w;
                if (k == 0 || w > mx[i])
                    mx[i] = w;
            end
        end
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = best[i] < 0 ? 64'(-best[i]) : 64'(best[i]);
            s = s + m * m;
        end
        len = root64(s);
        for (int i = 0; i < 3; i++)
        begin
            off = 0;
            if (len != 0)
            begin
                m = best[i] < 0 ? 64'(-best[i]) : 64'(best[i]);
                q = ({33'd0, it.bias} * m) / len;
                off = best[i] < 0 ? -$signed({32'd0, q}) : $signed({32'd0, q});
            end
            res.support[i] = clamp32(best[i] + off + pos[i]);
            res.bmin[i] = clamp32(mn[i]);
            res.bmax[i] = clamp32(mx[i]);
        end
        return res;
    endfunction

    function void note_query(obsb_pkg::in_t it);
        pending.insert(pending.size(), support_and_bounds(it));
    endfunction

    task check_result(obsb_pkg::result_t got);
        obsb_pkg::result_t want;
        if (pending.size() == 0)
        begin
            report_mismatch("unexpected result beat", got.support[0], 32'd0);
            return;
        end
        want = pending.pop_front();
        for (int i = 0; i < 3; i++)
        begin
            if (got.support[i] !== want.support[i])
                report_mismatch($sformatf("support[%0d]", i), got.support[i], want.support[i]);
            if (got.bmin[i] !== want.bmin[i])
                report_mismatch($sformatf("bound_min[%0d]", i), got.bmin[i], want.bmin[i]);
            if (got.bmax[i] !== want.bmax[i])
                report_mismatch($sformatf("bound_max[%0d]", i), got.bmax[i], want.bmax[i]);
        end
    endtask
endclass

module oriented_box_support_and_bounds_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import obsb_pkg::*;

    localparam int LATENCY = 72;
    localparam int STALL_LIMIT = 5000;
    localparam logic [29:0] HE_MAX = 30'h3fff_ffff;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [287:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [287:0] m_tdata;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [HE_W-1:0] cfg_data;

    box_support_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    oriented_box_support_and_bounds_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_query(in_t'(s_tdata));
            if (m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("oriented_box_support_and_bounds_unit_tb: errors");
                $finish;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic in_t make_query(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                                       logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                                       logic [15:0] qz, logic [30:0] bias);
        in_t it;
        it.pad = 1'b0;
        it.dir[0] = dx;
        it.dir[1] = dy;
        it.dir[2] = dz;
        it.pos[0] = px;
        it.pos[1] = py;
        it.pos[2] = pz;
        it.qw = qw;
        it.qx = qx;
        it.qy = qy;
        it.qz = qz;
        it.bias = bias;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(3) == 0)
            return v;
        // mostly a few units either way
        return {{12{v[31]}}, v[19:0]};
    endfunction

    function automatic logic [15:0] rand_quat_part();
        logic [15:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0: return v;
            1: return {{2{v[15]}}, v[13:0]};
            2: return v[0] ? 16'sh7fff : 16'sh8000;
            default: return (v[0] ? 16'sh5a82 : -16'sh5a82) & {16{v[1]}};
        endcase
    endfunction

    task automatic send_query(in_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_extent(logic [IDX_W-1:0] idx, logic [29:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.half_ext[idx] = val;
        cfg_we <= 1'b0;
    endtask

    // hold off until the pipe has drained
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic directed_queries();
        logic [31:0] one;
        one = 32'h0001_0000;
        send_query(make_query(0, 0, 0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0));
        send_query(make_query(one, 0, 0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 31'h7fff_ffff));
        send_query(make_query(0, -one, 0, one, one, one, 16'sh7fff, 0, 0, 0, 31'h0001_0000));
        send_query(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 31'h7fff_ffff));
        send_query(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0));
        send_query(make_query(one, one, one, 0, 0, 0, 0, 0, 0, 0, 31'h0010_0000));
        send_query(make_query(one, 0, one, 0, 0, 0, 16'sh5a82, 16'sh5a82, 0, 0, 31'd5));
        send_query(make_query(-one, one, 0, 0, 0, 0, 16'sh5a82, 0, 16'sh5a82, 0, 31'd1));
        send_query(make_query(0, one, -one, 0, 0, 0, 16'sh5a82, 0, 0, -16'sh5a82, 31'd7));
        send_query(make_query(0, 0, one, 32'h7fff_0000, 32'h8001_0000, 0,
                              0, 16'sh7fff, 0, 0, 31'h0002_0000));
        send_query(make_query(32'hffff_ffff, 1, 32'hffff_ffff, 0, 0, 0,
                              16'sh8000, 0, 0, 0, 31'h4000_0000));
        send_query(make_query(one, one, 0, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0));
    endtask

    initial
    begin
        in_t it;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_HALF_X;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_queries();
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_extent(REG_HALF_X, HE_MAX);
                    write_extent(REG_HALF_Y, HE_MAX);
                    write_extent(REG_HALF_Z, HE_MAX);
                end
                1:
                begin
                    write_extent(REG_HALF_X, 30'd0);
                    write_extent(REG_HALF_Y, 30'd0);
                    write_extent(REG_HALF_Z, 30'd0);
                end
                2:
                begin
                    write_extent(REG_HALF_X, 30'd0);
                    write_extent(REG_HALF_Y, 30'h0003_0000);
                    write_extent(REG_HALF_Z, HE_MAX);
                end
                default:
                begin
                    write_extent(REG_HALF_X, 30'($urandom_range(30'h0010_0000)));
                    write_extent(REG_HALF_Y, 30'($urandom()));
                    write_extent(REG_HALF_Z, 30'($urandom_range(30'h0004_0000)));
                end
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 1)
                directed_queries();
            for (int n = 0; n < 105; n++)
            begin
                it = make_query(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord(),
                                rand_quat_part(), rand_quat_part(), rand_quat_part(),
                                rand_quat_part(),
                                $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(1 << 18)));
                send_query(it);
            end
        end
        drain();
        if (sb.errors == 0)
            $display("oriented_box_support_and_bounds_unit_tb: clean");
        else
            $display("oriented_box_support_and_bounds_unit_tb: errors");
        $finish;
    end
endmodule

@@ oriented_box_support_and_bounds_unit.f @@
rtl/obsb_pkg.sv
rtl/obsb_geom.sv
rtl/obsb_norm.sv
rtl/oriented_box_support_and_bounds_unit.sv
dv/oriented_box_support_and_bounds_unit_tb.sv
